>>> sv/text_cell_glyph_renderer_assert.svh
// Assertion macros shared by the checker of the text cell glyph renderer.
`ifndef TEXT_CELL_GLYPH_RENDERER_ASSERT_SVH
`define TEXT_CELL_GLYPH_RENDERER_ASSERT_SVH

// Same-cycle implication, sampled on aclk, off while reset is held.
`define TCG_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("tcg assertion failed");

// Next-cycle implication, sampled on aclk, off while reset is held.
`define TCG_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("tcg assertion failed");

`endif

>>> sv/tcg_pkg.sv
// Shared types and constants of the text cell glyph renderer.
`timescale 1ns / 1ps

package tcg_pkg;

    localparam int unsigned IDX_W       = 10;
    localparam int unsigned ADDR_W      = 19;
    localparam int unsigned COLOR_W     = 32;
    localparam int unsigned GLYPH_ROWS  = 16;
    localparam int unsigned ROW_W       = 4;
    localparam int unsigned GLYPH_W     = 8;
    localparam int unsigned PAL_DEPTH   = 256;
    localparam int unsigned PAL_W       = 8;
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = 2;

    typedef enum logic [1:0] {
        OP_RENDER  = 2'd0,
        OP_FONT    = 2'd1,
        OP_PALETTE = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        CMD_RENDER,
        CMD_FONT,
        CMD_PAL
    } cmd_t;

    typedef struct packed {
        cmd_t               cmd;
        logic [IDX_W-1:0]   font_base;
        logic [PAL_W-1:0]   fg_idx;
        logic [PAL_W-1:0]   bg_idx;
        logic [ADDR_W-1:0]  base_addr;
        logic [IDX_W-1:0]   table_index;
        logic [COLOR_W-1:0] table_data;
    } item_t;

endpackage

>>> sv/tcg_modc.sv
// Pipelined remainder by a constant divisor, three stages.
`timescale 1ns / 1ps

module tcg_modc #(
    parameter int unsigned W = 16,
    parameter int unsigned D = 256
) (
    input  logic         aclk,
    input  logic         en,
    input  logic [W-1:0] x,
    output logic [W-1:0] y
);

    // Reciprocal estimate is low by at most one quotient step
    localparam int unsigned MV = (1 << W) / D;

    logic [2*W:0] prod;
    logic [W:0]   q_reg;
    logic [W-1:0] x1_reg;
    logic [W:0]   r_reg;
    logic [W-1:0] y_reg;

    assign prod = (2*W+1)'(x) * (2*W+1)'(MV);
    assign y    = y_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            q_reg  <= prod[2*W:W];
            x1_reg <= x;
            r_reg  <= (W+1)'(x1_reg) - (W+1)'(q_reg * D);
            // fix the one-off estimate
            y_reg  <= (32'(r_reg) >= D) ? W'(r_reg - (W+1)'(D)) : W'(r_reg);
        end
    end

endmodule

>>> sv/tcg_front.sv
// Front end: accept, classify and wrap transfers, form the cell base address.
`timescale 1ns / 1ps

module tcg_front #(
    parameter int unsigned GLYPHS       = 256,
    parameter int unsigned TEXT_COLUMNS = 100,
    parameter int unsigned TEXT_ROWS    = 28
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [1:0]                     s_operation,
    input  logic [31:0]                    s_cell_word,
    input  logic [6:0]                     s_cell_column,
    input  logic [4:0]                     s_cell_row,
    input  logic [tcg_pkg::IDX_W-1:0]      s_table_index,
    input  logic [tcg_pkg::COLOR_W-1:0]    s_table_data,
    output logic                           q_valid,
    input  logic                           q_ready,
    output tcg_pkg::item_t                 q_item
);

    localparam int unsigned FONT_WORDS = 4 * GLYPHS;
    localparam int unsigned ROW_PIXELS =
        tcg_pkg::GLYPH_ROWS * tcg_pkg::GLYPH_W * TEXT_COLUMNS;
    localparam int unsigned LAT = 3;

    typedef struct packed {
        tcg_pkg::cmd_t                     cmd;
        logic [tcg_pkg::PAL_W-1:0]         fg_idx;
        logic [tcg_pkg::PAL_W-1:0]         bg_idx;
        logic [tcg_pkg::IDX_W-1:0]         table_index;
        logic [tcg_pkg::COLOR_W-1:0]       table_data;
    } side_t;

    logic           adv;
    logic           keep;
    tcg_pkg::cmd_t  cmd;
    side_t          side_in;
    side_t          side_reg [LAT];
    logic [LAT-1:0] valid_reg;
    logic           out_valid_reg;
    tcg_pkg::item_t item_reg;
    logic [15:0]    glyph_m;
    logic [6:0]     col_m;
    logic [4:0]     row_m;
    logic [17:0]    glyph_x4;

    // Stall the whole front only when the final stage cannot drain
    assign adv     = !out_valid_reg || q_ready;
    assign s_ready = adv;
    assign q_valid = out_valid_reg;
    assign q_item  = item_reg;

    always_comb begin
        keep = 1'b0;
        cmd  = tcg_pkg::CMD_RENDER;
        case (s_operation)
            tcg_pkg::OP_RENDER: begin
                keep = 1'b1;
                cmd  = tcg_pkg::CMD_RENDER;
            end
            tcg_pkg::OP_FONT: begin
                keep = 32'(s_table_index) < FONT_WORDS;
                cmd  = tcg_pkg::CMD_FONT;
            end
            tcg_pkg::OP_PALETTE: begin
                keep = 32'(s_table_index) < tcg_pkg::PAL_DEPTH;
                cmd  = tcg_pkg::CMD_PAL;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    always_comb begin
        side_in.cmd         = cmd;
        side_in.fg_idx      = s_cell_word[23:16];
        side_in.bg_idx      = s_cell_word[31:24];
        side_in.table_index = s_table_index;
        side_in.table_data  = s_table_data;
    end

    tcg_modc #(.W(16), .D(GLYPHS)) u_glyph_mod (
        .aclk (aclk), .en (adv), .x (s_cell_word[15:0]), .y (glyph_m)
    );

    tcg_modc #(.W(7), .D(TEXT_COLUMNS)) u_col_mod (
        .aclk (aclk), .en (adv), .x (s_cell_column), .y (col_m)
    );

    tcg_modc #(.W(5), .D(TEXT_ROWS)) u_row_mod (
        .aclk (aclk), .en (adv), .x (s_cell_row), .y (row_m)
    );

    assign glyph_x4 = {glyph_m, 2'b00};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg     <= {valid_reg[LAT-2:0], s_valid && keep};
            out_valid_reg <= valid_reg[LAT-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            side_reg[0] <= side_in;
            for (int i = 1; i < LAT; i++) begin
                side_reg[i] <= side_reg[i-1];
            end
            item_reg.cmd         <= side_reg[LAT-1].cmd;
            item_reg.fg_idx      <= side_reg[LAT-1].fg_idx;
            item_reg.bg_idx      <= side_reg[LAT-1].bg_idx;
            item_reg.table_index <= side_reg[LAT-1].table_index;
            item_reg.table_data  <= side_reg[LAT-1].table_data;
            item_reg.font_base   <= glyph_x4[tcg_pkg::IDX_W-1:0];
            item_reg.base_addr   <= tcg_pkg::ADDR_W'(32'(row_m) * ROW_PIXELS)
                                  + tcg_pkg::ADDR_W'({col_m, 3'b000});
        end
    end

endmodule

>>> sv/tcg_queue.sv
// Short queue between front end and back end.
`timescale 1ns / 1ps

module tcg_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  tcg_pkg::item_t in_item,
    output logic           out_valid,
    input  logic           out_ready,
    output tcg_pkg::item_t out_item
);

    tcg_pkg::item_t                  entry_reg [tcg_pkg::QUEUE_DEPTH];
    logic [tcg_pkg::QPTR_W-1:0]      wr_ptr_reg;
    logic [tcg_pkg::QPTR_W-1:0]      rd_ptr_reg;
    logic [tcg_pkg::QPTR_W:0]        count_reg;
    logic                            push;
    logic                            pop;

    assign in_ready  = count_reg != (tcg_pkg::QPTR_W+1)'(tcg_pkg::QUEUE_DEPTH);
    assign out_valid = count_reg != '0;
    assign out_item  = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

>>> sv/tcg_back.sv
// Back end: font and palette stores, row sequencing and pixel color expansion.
`timescale 1ns / 1ps

module tcg_back #(
    parameter int unsigned GLYPHS       = 256,
    parameter int unsigned TEXT_COLUMNS = 100
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         q_valid,
    output logic                         q_ready,
    input  tcg_pkg::item_t               q_item,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [tcg_pkg::ADDR_W-1:0]   m_pixel_address,
    output logic [tcg_pkg::COLOR_W-1:0]  m_color [tcg_pkg::GLYPH_W],
    output logic                         m_last_row
);

    localparam int unsigned FONT_WORDS  = 4 * GLYPHS;
    localparam int unsigned FONT_DEPTH  =
        (FONT_WORDS < (1 << tcg_pkg::IDX_W)) ? FONT_WORDS : (1 << tcg_pkg::IDX_W);
    localparam int unsigned FA          = $clog2(FONT_DEPTH);
    localparam int unsigned LINE_PIXELS = tcg_pkg::GLYPH_W * TEXT_COLUMNS;

    logic [tcg_pkg::COLOR_W-1:0] font_mem [FONT_DEPTH];
    logic [tcg_pkg::COLOR_W-1:0] pal_mem  [tcg_pkg::PAL_DEPTH];

    logic                          en;
    logic                          is_render;
    logic                          issue;
    logic                          last_issue;
    logic [FA-1:0]                 font_rd_addr;
    logic [tcg_pkg::ADDR_W-1:0]    cur_addr;
    logic [tcg_pkg::ROW_W-1:0]     row_cnt_reg;
    logic [tcg_pkg::ADDR_W-1:0]    row_addr_reg;
    logic                          b_valid_reg;
    logic [tcg_pkg::ROW_W-1:0]     b_row_reg;
    logic [tcg_pkg::ADDR_W-1:0]    b_addr_reg;
    logic [tcg_pkg::COLOR_W-1:0]   word_reg;
    logic [tcg_pkg::COLOR_W-1:0]   fg_reg;
    logic [tcg_pkg::COLOR_W-1:0]   bg_reg;
    logic [tcg_pkg::GLYPH_W-1:0]   row_bits;
    logic                          m_valid_reg;
    logic [tcg_pkg::ADDR_W-1:0]    m_addr_reg;
    logic [tcg_pkg::COLOR_W-1:0]   m_color_reg [tcg_pkg::GLYPH_W];
    logic                          m_last_reg;

    assign en         = !m_valid_reg || m_ready;
    assign is_render  = q_item.cmd == tcg_pkg::CMD_RENDER;
    assign issue      = en && q_valid;
    assign last_issue = row_cnt_reg == tcg_pkg::ROW_W'(tcg_pkg::GLYPH_ROWS - 1);
    // Loads retire at once; a render retires with its last row
    assign q_ready    = en && (!is_render || last_issue);
    assign cur_addr   = (row_cnt_reg == '0) ? q_item.base_addr : row_addr_reg;
    assign font_rd_addr = q_item.font_base[FA-1:0] | FA'(row_cnt_reg[3:2]);
    assign row_bits   = word_reg[{b_row_reg[1:0], 3'b000} +: tcg_pkg::GLYPH_W];

    assign m_valid         = m_valid_reg;
    assign m_pixel_address = m_addr_reg;
    assign m_color         = m_color_reg;
    assign m_last_row      = m_last_reg;

    always_ff @(posedge aclk) begin
        if (issue && q_item.cmd == tcg_pkg::CMD_FONT) begin
            font_mem[q_item.table_index[FA-1:0]] <= q_item.table_data;
        end
        if (issue && q_item.cmd == tcg_pkg::CMD_PAL) begin
            pal_mem[q_item.table_index[tcg_pkg::PAL_W-1:0]] <= q_item.table_data;
        end
        if (en) begin
            word_reg <= font_mem[font_rd_addr];
            fg_reg   <= pal_mem[q_item.fg_idx];
            bg_reg   <= pal_mem[q_item.bg_idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_cnt_reg <= '0;
            b_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (en) begin
            b_valid_reg <= q_valid && is_render;
            m_valid_reg <= b_valid_reg;
            if (q_valid && is_render) begin
                row_cnt_reg <= row_cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            if (q_valid && is_render) begin
                row_addr_reg <= cur_addr + tcg_pkg::ADDR_W'(LINE_PIXELS);
            end
            b_row_reg  <= row_cnt_reg;
            b_addr_reg <= cur_addr;
            m_addr_reg <= b_addr_reg;
            m_last_reg <= b_row_reg == tcg_pkg::ROW_W'(tcg_pkg::GLYPH_ROWS - 1);
            for (int c = 0; c < tcg_pkg::GLYPH_W; c++) begin
                m_color_reg[c] <= row_bits[tcg_pkg::GLYPH_W-1-c] ? fg_reg : bg_reg;
            end
        end
    end

endmodule

>>> sv/text_cell_glyph_renderer.sv
// Top level of the 8x16 text-mode character generator.
`timescale 1ns / 1ps

// Text-mode character generator for 8x16 one-bit glyphs. Each transfer on
// the s_ side is one operation: a font word load (four words per glyph), a
// palette entry load, or a cell render. Loads give no result and retire
// from the back end at once; a load with an index past its store, and the
// unused operation code, are dropped at the front without reaching the
// back end. A render gives sixteen transfers on the m_ side, top glyph row
// first, each with the linear pixel address of the row start and the eight
// pixel colors, leftmost in m_color_0; m_last_row marks the sixteenth. A
// render holds the back end, which gives one glyph row per cycle while
// m_ready does not stall it, as set by the single read port of the font
// store; a new transfer is taken every cycle as long as the four-entry
// queue between front and back has room. The front wraps glyph, column and
// row, then forms the address; the queue and the back, with its store
// reads and color expansion, follow. Font and palette stores come up
// undefined and need no clearing pass: only entries loaded before use may
// be rendered.
module text_cell_glyph_renderer #(
    parameter int unsigned GLYPHS       = 256,
    parameter int unsigned TEXT_COLUMNS = 100,
    parameter int unsigned TEXT_ROWS    = 28
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_operation,
    input  logic [31:0] s_cell_word,
    input  logic [6:0]  s_cell_column,
    input  logic [4:0]  s_cell_row,
    input  logic [9:0]  s_table_index,
    input  logic [31:0] s_table_data,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [18:0] m_pixel_address,
    output logic [31:0] m_color_0,
    output logic [31:0] m_color_1,
    output logic [31:0] m_color_2,
    output logic [31:0] m_color_3,
    output logic [31:0] m_color_4,
    output logic [31:0] m_color_5,
    output logic [31:0] m_color_6,
    output logic [31:0] m_color_7,
    output logic        m_last_row
);

    // Front to queue
    logic                        fq_valid;
    logic                        fq_ready;
    tcg_pkg::item_t              fq_item;
    // Queue to back
    logic                        qb_valid;
    logic                        qb_ready;
    tcg_pkg::item_t              qb_item;
    logic [tcg_pkg::COLOR_W-1:0] color [tcg_pkg::GLYPH_W];

    // Wrap cell position and glyph code, drop loads that fall outside a store and the unused operation code
    tcg_front #(
        .GLYPHS       (GLYPHS),
        .TEXT_COLUMNS (TEXT_COLUMNS),
        .TEXT_ROWS    (TEXT_ROWS)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_operation   (s_operation),
        .s_cell_word   (s_cell_word),
        .s_cell_column (s_cell_column),
        .s_cell_row    (s_cell_row),
        .s_table_index (s_table_index),
        .s_table_data  (s_table_data),
        .q_valid       (fq_valid),
        .q_ready       (fq_ready),
        .q_item        (fq_item)
    );

    // Absorb a few operations while a render holds the back end
    tcg_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_item   (fq_item),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_item  (qb_item)
    );

    // Apply loads in order with renders, expand glyph rows to colors
    tcg_back #(
        .GLYPHS       (GLYPHS),
        .TEXT_COLUMNS (TEXT_COLUMNS)
    ) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .q_valid         (qb_valid),
        .q_ready         (qb_ready),
        .q_item          (qb_item),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_pixel_address (m_pixel_address),
        .m_color         (color),
        .m_last_row      (m_last_row)
    );

    assign m_color_0 = color[0];
    assign m_color_1 = color[1];
    assign m_color_2 = color[2];
    assign m_color_3 = color[3];
    assign m_color_4 = color[4];
    assign m_color_5 = color[5];
    assign m_color_6 = color[6];
    assign m_color_7 = color[7];

endmodule

>>> sv/tcg_checker.sv
// Port-level checker of the text cell glyph renderer and its bind.
`timescale 1ns / 1ps
`include "text_cell_glyph_renderer_assert.svh"

module tcg_checker #(
    parameter int unsigned TEXT_COLUMNS = 100
) (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [18:0] m_pixel_address,
    input logic [31:0] m_color_0,
    input logic [31:0] m_color_7,
    input logic        m_last_row
);

    localparam logic [18:0] LINE_STEP = 19'(8 * TEXT_COLUMNS);

    // A stalled row holds its address, edge colors and row marker
    `TCG_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_pixel_address) && $stable(m_color_0) && $stable(m_color_7) && $stable(m_last_row))

    // Rows of one cell come without bubbles
    `TCG_ASSERT_NEXT(a_rows_back_to_back, m_valid && m_ready && !m_last_row, m_valid)

    // Consecutive rows of one cell are one screen line apart
    `TCG_ASSERT_NEXT(a_row_stride, m_valid && m_ready && !m_last_row, m_pixel_address == $past(m_pixel_address) + LINE_STEP)

endmodule

bind text_cell_glyph_renderer tcg_checker #(
    .TEXT_COLUMNS (TEXT_COLUMNS)
) u_tcg_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_pixel_address (m_pixel_address),
    .m_color_0       (m_color_0),
    .m_color_7       (m_color_7),
    .m_last_row      (m_last_row)
);
